/* rtl/pwm_duty_cycle_capture_assert.svh */
// Assertion macros for the PWM duty-cycle capture checker.
// Needs signals named clk and rst in the module that uses them.
`ifndef PWM_DUTY_CYCLE_CAPTURE_ASSERT_SVH
`define PWM_DUTY_CYCLE_CAPTURE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pdc_pkg.sv */
// Shared constants, codes and types of the PWM duty-cycle capture block.
// No dependencies; imported by every module of the block.
`default_nettype none

package pdc_pkg;

  localparam int TIMER_BITS = 16;
  localparam int STAMP_W    = 32;
  localparam int CAP_W      = 16;
  localparam int OVF_W      = 16;
  localparam int DUTY_W     = 7;
  localparam int DIGIT_W    = 4;
  localparam int DIGITS     = STAMP_W / DIGIT_W;
  localparam int STEP_W     = $clog2(DIGITS);
  localparam int PROD_W     = STAMP_W + DUTY_W;

  localparam int OUT_FIELDS_W = 1 + 2 * STAMP_W + DUTY_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CAP_W-1:0] CAP_MASK =
    (TIMER_BITS >= CAP_W) ? {CAP_W{1'b1}} : CAP_W'((1 << TIMER_BITS) - 1);

  localparam logic [DUTY_W-1:0] PCT_SCALE = 7'd100;

  localparam logic [1:0] PH_RISE1 = 2'd0;
  localparam logic [1:0] PH_FALL  = 2'd1;
  localparam logic [1:0] PH_RISE2 = 2'd2;

  localparam logic KIND_CAPTURE = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  localparam logic EDGE_RISE = 1'b0;
  localparam logic EDGE_FALL = 1'b1;

  typedef logic [STAMP_W-1:0] stamp_t;

  typedef struct packed {
    stamp_t             high;
    stamp_t             period;
    logic [DUTY_W-1:0]  duty;
  } eng_res_t;

endpackage

`default_nettype wire

/* rtl/pdc_engine.sv */
// Serial measurement engine: digit-serial timestamp subtraction and a
// bit-per-cycle restoring divider for the duty percentage. Uses pdc_pkg.
`default_nettype none

module pdc_engine
  import pdc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire stamp_t   rise,
  input  wire stamp_t   fall,
  input  wire stamp_t   second,
  output logic          done,
  output eng_res_t      res
);

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_SUB  = 2'd1;
  localparam logic [1:0] E_MUL  = 2'd2;
  localparam logic [1:0] E_DIV  = 2'd3;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIGITS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DUTY_W - 1);

  logic [1:0]        st;
  logic [STEP_W-1:0] cnt;
  stamp_t            sh_rise;
  stamp_t            sh_fall;
  stamp_t            sh_sec;
  stamp_t            high_sh;
  stamp_t            per_sh;
  logic              b_h;
  logic              b_p;
  logic              b_c;
  logic              pnz;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] dsh;
  logic [DUTY_W-1:0] quo;
  logic [DUTY_W-1:0] duty;

  logic [DIGIT_W:0]  dif_h;
  logic [DIGIT_W:0]  dif_p;
  logic [DIGIT_W:0]  dif_c;
  logic [PROD_W:0]   trial;
  logic              take;
  logic [PROD_W-1:0] prod;

  always_comb begin
    dif_h = {1'b0, sh_fall[DIGIT_W-1:0]} - {1'b0, sh_rise[DIGIT_W-1:0]}
            - (DIGIT_W+1)'(b_h);
    dif_p = {1'b0, sh_sec[DIGIT_W-1:0]} - {1'b0, sh_rise[DIGIT_W-1:0]}
            - (DIGIT_W+1)'(b_p);
    dif_c = {1'b0, dif_h[DIGIT_W-1:0]} - {1'b0, dif_p[DIGIT_W-1:0]}
            - (DIGIT_W+1)'(b_c);
    trial = {1'b0, rem} - {1'b0, dsh};
    take  = !trial[PROD_W];
    prod  = PROD_W'(high_sh) * PROD_W'(PCT_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= E_IDLE;
      done <= 1'b0;
    end else begin
      case (st)
        E_IDLE: begin
          done <= 1'b0;
          if (start) begin
            sh_rise <= rise;
            sh_fall <= fall;
            sh_sec  <= second;
            b_h     <= 1'b0;
            b_p     <= 1'b0;
            b_c     <= 1'b0;
            pnz     <= 1'b0;
            cnt     <= '0;
            st      <= E_SUB;
          end
        end
        E_SUB: begin
          // advance one digit of high, period and the high-vs-period compare
          done    <= 1'b0;
          sh_rise <= sh_rise >> DIGIT_W;
          sh_fall <= sh_fall >> DIGIT_W;
          sh_sec  <= sh_sec >> DIGIT_W;
          high_sh <= {dif_h[DIGIT_W-1:0], high_sh[STAMP_W-1:DIGIT_W]};
          per_sh  <= {dif_p[DIGIT_W-1:0], per_sh[STAMP_W-1:DIGIT_W]};
          b_h     <= dif_h[DIGIT_W];
          b_p     <= dif_p[DIGIT_W];
          b_c     <= dif_c[DIGIT_W];
          pnz     <= pnz | (|dif_p[DIGIT_W-1:0]);
          cnt     <= cnt + 1'b1;
          if (cnt == STEP_LAST) begin
            st <= E_MUL;
          end
        end
        E_MUL: begin
          if (!pnz) begin
            duty <= '0;
            done <= 1'b1;
            st   <= E_IDLE;
          end else if (!b_c) begin
            duty <= PCT_SCALE;
            done <= 1'b1;
            st   <= E_IDLE;
          end else begin
            done <= 1'b0;
            rem  <= prod;
            dsh  <= PROD_W'(per_sh) << (DUTY_W - 1);
            cnt  <= '0;
            st   <= E_DIV;
          end
        end
        E_DIV: begin
          if (take) begin
            rem <= trial[PROD_W-1:0];
          end
          quo  <= {quo[DUTY_W-2:0], take};
          dsh  <= dsh >> 1;
          cnt  <= cnt + 1'b1;
          done <= (cnt == DIV_LAST);
          if (cnt == DIV_LAST) begin
            duty <= {quo[DUTY_W-2:0], take};
            st   <= E_IDLE;
          end
        end
        default: begin
          done <= 1'b0;
          st   <= E_IDLE;
        end
      endcase
    end
  end

  assign res.high   = high_sh;
  assign res.period = per_sh;
  assign res.duty   = duty;

endmodule

`default_nettype wire

/* rtl/pwm_duty_cycle_capture.sv */
// PWM duty-cycle capture: top level with the capture phase sequencer,
// overflow counter and output register. Uses pdc_pkg and pdc_engine.
//
// Feed one beat per timer event: tuser high for an overflow tick, low for a
// capture with the latched timer value in tdata. Every input beat yields one
// output beat giving the edge to arm next; the third capture of a cycle also
// carries high time, period and duty percent, with tuser set. Ticks and the
// first two captures go through the hold state into the output register; the
// closing capture also goes through the 4-bit-per-cycle timestamp
// subtractors and the one-bit-per-cycle duty divider, which is skipped
// when the period is zero or no longer than the high time. One input beat
// is processed at a time; a finished beat waits in the output register
// while the next input beat is taken.
`default_nettype none

module pwm_duty_cycle_capture
  import pdc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [CAP_W-1:0]       s_tdata,  // capture_value
  input  wire logic                   s_tuser,  // kind
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,  // next_edge, high_ticks, period_ticks,
                                                // duty_percent
  output logic                        m_tuser   // done_res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]        st;
  logic [1:0]        phase;
  logic [OVF_W-1:0]  ovf;
  stamp_t            rise_stamp;
  stamp_t            fall_stamp;
  stamp_t            sec_stamp;
  logic              start;

  logic              res_edge;
  logic              res_done;
  eng_res_t          res;

  logic              eng_done;
  eng_res_t          eng_res;

  logic              acc;
  logic              out_free;
  stamp_t            ovf_shift;
  stamp_t            stamp;

  assign s_tready = (st == S_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    ovf_shift = STAMP_W'(ovf) << TIMER_BITS;
    stamp     = ovf_shift | STAMP_W'(s_tdata & CAP_MASK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      phase <= PH_RISE1;
      ovf   <= '0;
      start <= 1'b0;
    end else begin
      start <= acc && (s_tuser == KIND_CAPTURE) && (phase == PH_RISE2);
      case (st)
        S_IDLE: begin
          if (acc) begin
            res_done <= 1'b0;
            res      <= '0;
            if (s_tuser == KIND_TICK) begin
              ovf      <= ovf + 1'b1;
              res_edge <= (phase == PH_FALL) ? EDGE_FALL : EDGE_RISE;
              st       <= S_HOLD;
            end else begin
              case (phase)
                PH_FALL: begin
                  fall_stamp <= stamp;
                  phase      <= PH_RISE2;
                  res_edge   <= EDGE_RISE;
                  st         <= S_HOLD;
                end
                PH_RISE2: begin
                  sec_stamp <= stamp;
                  phase     <= PH_RISE1;
                  ovf       <= '0;
                  st        <= S_CALC;
                end
                default: begin
                  rise_stamp <= stamp;
                  phase      <= PH_FALL;
                  res_edge   <= EDGE_FALL;
                  st         <= S_HOLD;
                end
              endcase
            end
          end
        end
        S_CALC: begin
          if (eng_done) begin
            res_edge <= EDGE_RISE;
            res_done <= 1'b1;
            res      <= eng_res;
            st       <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (st == S_HOLD && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= OUT_TDATA_W'({res.duty, res.period, res.high, res_edge});
      m_tuser  <= res_done;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  pdc_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .rise   (rise_stamp),
    .fall   (fall_stamp),
    .second (sec_stamp),
    .done   (eng_done),
    .res    (eng_res)
  );

endmodule

`default_nettype wire

/* rtl/pdc_checker.sv */
// Port-level checker for the PWM duty-cycle capture block, bound to the top.
// Uses pdc_pkg and the macros of pwm_duty_cycle_capture_assert.svh.
`default_nettype none

`include "pwm_duty_cycle_capture_assert.svh"

module pdc_checker
  import pdc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic                   m_tuser
);

  logic [DUTY_W-1:0]      duty;
  logic [OUT_TDATA_W-2:0] meas;
  logic [OUT_TDATA_W:0]   beat;
  logic                   in_beat;
  logic                   out_stall;

  assign duty      = m_tdata[OUT_TDATA_W-1 -: DUTY_W];
  assign meas      = m_tdata[OUT_TDATA_W-1:1];
  assign beat      = {m_tuser, m_tdata};
  assign in_beat   = s_tvalid && s_tready;
  assign out_stall = m_tvalid && !m_tready;

  `PDC_ASSERT_NOW(a_duty_range, m_tvalid, duty <= PCT_SCALE, "duty above 100")
  `PDC_ASSERT_NOW(a_idle_zero, m_tvalid && !m_tuser, meas == '0, "fields without done")
  `PDC_ASSERT_NOW(a_done_rise, m_tvalid && m_tuser, m_tdata[0] == EDGE_RISE, "done arms fall")
  `PDC_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(beat), "stalled beat changed")
  `PDC_ASSERT_NEXT(a_one_beat, in_beat, !s_tready, "input taken while busy")

endmodule

bind pwm_duty_cycle_capture pdc_checker u_pdc_checker (.*);

`default_nettype wire

/* test/testbench.sv */
// Testbench for pwm_duty_cycle_capture: drives tick and capture beats with
// bursty input and a stalling output, predicts every result beat from its own
// model of the capture phases, and checks each field. Depends on rtl/pdc_pkg.sv.
`default_nettype none

module testbench;
  import pdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  PERIOD      = 20;
  localparam int  CYCLE_LIMIT = 2_000_000;
  localparam int  RANDOM_BEATS = 1350;
  localparam int  PERCENT     = 100;

  typedef struct {
    logic              next_edge;
    logic              done;
    stamp_t            high;
    stamp_t            period;
    logic [DUTY_W-1:0] duty;
  } capture_report_t;

  class duty_capture_tracker;
    logic [1:0]       phase;
    logic [OVF_W-1:0] ovf_count;
    stamp_t           rise_stamp;
    stamp_t           fall_stamp;
    capture_report_t  expected_reports[$];
    int               error_count;
    int               tick_count;
    int               measure_count;
    int               clamp_count;
    int               zero_period_count;

    function new();
      phase = PH_RISE1;
      ovf_count = '0;
      rise_stamp = '0;
      fall_stamp = '0;
      error_count = 0;
      tick_count = 0;
      measure_count = 0;
      clamp_count = 0;
      zero_period_count = 0;
    endfunction

    function stamp_t form_stamp(logic [CAP_W-1:0] cap);
      logic [63:0] lowmask;
      logic [63:0] full;
      lowmask = (64'd1 << TIMER_BITS) - 64'd1;
      full = (64'(ovf_count) << TIMER_BITS) + (64'(cap) & lowmask);
      return full[STAMP_W-1:0];
    endfunction

    function logic [DUTY_W-1:0] duty_of(stamp_t high, stamp_t period);
      logic [63:0] q;
      if (period == '0) begin
        zero_period_count++;
        return '0;
      end
      q = (64'(high) * 64'(PERCENT)) / 64'(period);
      if (q > 64'(PERCENT)) begin
        clamp_count++;
        q = 64'(PERCENT);
      end
      return q[DUTY_W-1:0];
    endfunction

    function void note_event(logic kind, logic [CAP_W-1:0] cap);
      capture_report_t r;
      stamp_t          stamp;
      r = '{default: '0};
      stamp = form_stamp(cap);
      if (kind == KIND_TICK) begin
        tick_count++;
        ovf_count = ovf_count + 1'b1;
        r.next_edge = (phase == PH_FALL) ? EDGE_FALL : EDGE_RISE;
      end else if (phase == PH_FALL) begin
        fall_stamp = stamp;
        phase = PH_RISE2;
        r.next_edge = EDGE_RISE;
      end else if (phase == PH_RISE2) begin
        measure_count++;
        r.high = fall_stamp - rise_stamp;
        r.period = stamp - rise_stamp;
        r.duty = duty_of(r.high, r.period);
        r.done = 1'b1;
        r.next_edge = EDGE_RISE;
        phase = PH_RISE1;
        ovf_count = '0;
      end else begin
        rise_stamp = stamp;
        phase = PH_FALL;
        r.next_edge = EDGE_FALL;
      end
      expected_reports.push_back(r);
    endfunction

    function void check_report(logic [OUT_TDATA_W-1:0] data, logic done);
      capture_report_t exp_r;
      capture_report_t got;
      if (expected_reports.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat tdata=%h tuser=%b", $time, data, done);
        return;
      end
      exp_r = expected_reports.pop_front();
      got.next_edge = data[0];
      got.high      = data[1 +: STAMP_W];
      got.period    = data[1 + STAMP_W +: STAMP_W];
      got.duty      = data[1 + 2 * STAMP_W +: DUTY_W];
      got.done      = done;
      if (got.next_edge !== exp_r.next_edge) begin
        error_count++;
        $display("%0t: next_edge expected %b actual %b", $time, exp_r.next_edge, got.next_edge);
      end
      if (got.done !== exp_r.done) begin
        error_count++;
        $display("%0t: done_res expected %b actual %b", $time, exp_r.done, got.done);
      end
      if (got.high !== exp_r.high) begin
        error_count++;
        $display("%0t: high_ticks expected %h actual %h", $time, exp_r.high, got.high);
      end
      if (got.period !== exp_r.period) begin
        error_count++;
        $display("%0t: period_ticks expected %h actual %h", $time, exp_r.period, got.period);
      end
      if (got.duty !== exp_r.duty) begin
        error_count++;
        $display("%0t: duty_percent expected %0d actual %0d", $time, exp_r.duty, got.duty);
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [CAP_W-1:0]       s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  duty_capture_tracker tracker = new();
  int                  cycle_count = 0;
  int                  stall_mode = 0;
  int                  beats_sent = 0;

  pwm_duty_cycle_capture uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #(PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               tracker.pending());
      $display("FAIL pwm_duty_cycle_capture");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        tracker.note_event(s_tuser, s_tdata);
      if (m_tvalid && m_tready)
        tracker.check_report(m_tdata, m_tuser);
    end
  end

  always @(negedge clk) begin
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ((cycle_count % 7) < 3);
      default: m_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  task automatic send_event(input logic kind, input logic [CAP_W-1:0] cap);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= cap;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic hold_off(input int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tuser  <= 1'($urandom);
    s_tdata  <= CAP_W'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    hold_off(1);
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  task automatic send_measurement(input logic [CAP_W-1:0] r1, input logic [CAP_W-1:0] f,
                                  input logic [CAP_W-1:0] r2);
    send_event(KIND_CAPTURE, r1);
    send_event(KIND_CAPTURE, f);
    send_event(KIND_CAPTURE, r2);
  endtask

  initial begin
    int burst;
    int gap;
    logic kind;
    logic [CAP_W-1:0] cap;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: tick in every phase, field extremes, zero period, clamp, wrap-around
    stall_mode = 1;
    send_event(KIND_TICK, 16'hFFFF);
    send_event(KIND_CAPTURE, 16'h0000);
    send_event(KIND_TICK, 16'h0000);
    send_event(KIND_CAPTURE, 16'hFFFF);
    send_event(KIND_TICK, 16'h1234);
    send_event(KIND_CAPTURE, 16'h0000);
    send_measurement(16'h0005, 16'h0005, 16'h0005);
    send_measurement(16'd100, 16'd300, 16'd200);
    send_measurement(16'd500, 16'd100, 16'd50);
    send_measurement(16'hAAAA, 16'h5555, 16'hFFFF);
    send_measurement(16'h0000, 16'h7FFF, 16'hFFFF);
    drain();

    while (beats_sent < RANDOM_BEATS) begin
      if ((beats_sent % 200) < 8)
        stall_mode = $urandom_range(0, 3);
      if (beats_sent > RANDOM_BEATS / 2 && beats_sent < RANDOM_BEATS / 2 + 15)
        drain();
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        kind = ($urandom_range(0, 2) == 0) ? KIND_TICK : KIND_CAPTURE;
        case ($urandom_range(0, 7))
          0: cap = '0;
          1: cap = '1;
          2: cap = CAP_W'($urandom_range(0, 15));
          default: cap = CAP_W'($urandom_range(0, 65535));
        endcase
        send_event(kind, cap);
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0)
        hold_off(gap);
    end

    drain();
    repeat (40) @(posedge clk);

    $display("Sent %0d beats: %0d overflow ticks, %0d measurements", beats_sent,
             tracker.tick_count, tracker.measure_count);
    $display("including %0d clamped duties and %0d zero periods",
             tracker.clamp_count, tracker.zero_period_count);
    if (tracker.error_count == 0 && tracker.pending() == 0)
      $display("PASS pwm_duty_cycle_capture");
    else
      $display("FAIL pwm_duty_cycle_capture");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/pdc_pkg.sv
rtl/pdc_engine.sv
rtl/pwm_duty_cycle_capture.sv
rtl/pdc_checker.sv
test/testbench.sv
